// ----- rtl/hsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Handle slot allocator package
// Shared sizes, request codes and the scan unit's request and response types.
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int SLOTS     = 256;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int FF_W      = $clog2(SLOTS + 1);   // holds SLOTS as "none"
    localparam int HND_W     = 9;                   // handle_out field width
    localparam int HIN_W     = 16;                  // handle_in field width
    localparam int WORD_W    = 32;
    localparam int ACT_W     = 3;
    localparam int DATA_W    = 3 * WORD_W;          // description, param A, param B

    // Free slot search works on groups of used bits.
    localparam int GROUP     = 16;
    localparam int GROUP_W   = $clog2(GROUP);
    localparam int NGROUPS   = SLOTS / GROUP;
    localparam int NGRP_W    = $clog2(NGROUPS);

    localparam int S_TDATA_W = 112;                 // handle_in + three words
    localparam int M_FIELD_W = 1 + HND_W + DATA_W;
    localparam int M_TDATA_W = 112;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_EXIST  = 3'd2,
        ACT_SET    = 3'd3,
        ACT_GET    = 3'd4
    } t_action;

    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] from;
    } t_scan_req;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_scan_rsp;

endpackage

// ----- rtl/handle_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Handle slot allocator
// A table of handle slots with create, delete, exist, set and get requests.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: tuser carries the request kind and
// tdata the handle and three data words. Every request returns exactly one
// beat on the master stream with a status bit, the created handle and the
// data words read by a get.
// A request is taken when the block is idle. The data words live in one
// single-port RAM with a registered read; the used bits, the remembered
// first free slot and the free count are flip-flops. The result is held in
// the status and handle registers and moves into the output register once
// that register is empty or draining; exist, set, get, delete and a failing
// create then return to idle. A create that leaves free slots first runs a
// two-stage circular search for the next free slot (group summary, then a
// search inside one group) and returns to idle when it completes.
// At reset all slots are free, the first free slot is slot 0 and the free
// count equals the number of slots; the RAM needs no clearing, since a
// create always writes zeros to the slot it hands out before a get can see
// it. When the receiver stalls, the result waits in the output register; the
// block takes one more request, holds its result until that register drains
// and takes nothing further in the meantime.
// ----------------------------------------------------------------------------
module handle_slot_allocator_top
    import hsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [ACT_W-1:0]     i_s_tuser,   // action
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // handle_in, description_in,
                                              // param_a_in, param_b_in
    // Result stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata    // status, handle_out,
                                              // description_out, param_a_out,
                                              // param_b_out, zero pad
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_SCAN
    } t_state;

    t_state                r_state,       n_state;
    logic [SLOTS-1:0]      r_used,        n_used;
    logic [FF_W-1:0]       r_first_free,  n_first_free;
    logic [FF_W-1:0]       r_free_count,  n_free_count;
    logic                  r_status,      n_status;
    logic [HND_W-1:0]      r_hout,        n_hout;
    logic                  r_get_ok,      n_get_ok;
    logic                  r_scan_pend,   n_scan_pend;
    logic [SLOT_W-1:0]     r_scan_from,   n_scan_from;
    logic                  r_m_valid,     n_m_valid;
    logic [M_TDATA_W-1:0]  r_m_data,      n_m_data;

    logic                  in_fire;
    logic                  out_load;
    t_action               act;
    logic [HIN_W-1:0]      h_in;
    logic [SLOT_W-1:0]     h_slot;
    logic                  h_ok;
    logic                  have_free;
    logic [SLOT_W-1:0]     new_slot;
    logic [DATA_W-1:0]     wr_words;

    logic                  ram_en;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_addr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [DATA_W-1:0]     ram_rdata;
    logic [DATA_W-1:0]     rd_words;

    t_scan_req             scan_req;
    t_scan_rsp             scan_rsp;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign act       = t_action'(i_s_tuser);
    assign h_in      = i_s_tdata[HIN_W-1:0];
    assign h_slot    = h_in[SLOT_W-1:0];
    assign wr_words  = i_s_tdata[HIN_W +: DATA_W];  // {param_b, param_a, description}
    assign h_ok      = (h_in < HIN_W'(SLOTS)) && r_used[h_slot];
    assign have_free = (r_first_free < FF_W'(SLOTS));
    assign new_slot  = r_first_free[SLOT_W-1:0];

    // The output register can take a new result when it is empty or draining.
    assign out_load  = (r_state == ST_RESP) && (!r_m_valid || i_m_tready);
    assign rd_words  = r_get_ok ? ram_rdata : '0;

    assign scan_req.start = out_load && r_scan_pend;
    assign scan_req.from  = r_scan_from;

    // Data word RAM access is issued on the request beat itself.
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = h_slot;
        ram_wdata = wr_words;
        if (in_fire) begin
            case (act)
                ACT_CREATE: begin
                    ram_en    = have_free;
                    ram_we    = 1'b1;
                    ram_addr  = new_slot;
                    ram_wdata = '0;
                end
                ACT_SET: begin
                    ram_en = h_ok;
                    ram_we = 1'b1;
                end
                ACT_GET: begin
                    ram_en = h_ok;
                end
                default: begin
                    ram_en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_first_free = r_first_free;
        n_free_count = r_free_count;
        n_status     = r_status;
        n_hout       = r_hout;
        n_get_ok     = r_get_ok;
        n_scan_pend  = r_scan_pend;
        n_scan_from  = r_scan_from;
        n_m_valid    = r_m_valid && !i_m_tready;
        n_m_data     = r_m_data;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state     = ST_RESP;
                    n_status    = 1'b1;
                    n_hout      = '0;
                    n_get_ok    = 1'b0;
                    n_scan_pend = 1'b0;
                    case (act)
                        ACT_CREATE: begin
                            if (have_free) begin
                                n_used[new_slot] = 1'b1;
                                n_free_count     = r_free_count - 1'b1;
                                n_status         = 1'b0;
                                n_hout           = HND_W'(new_slot);
                                n_scan_from      = (new_slot == SLOT_W'(SLOTS - 1)) ?
                                                   '0 : new_slot + 1'b1;
                                if (r_free_count == FF_W'(1)) begin
                                    n_first_free = FF_W'(SLOTS);
                                end else begin
                                    n_scan_pend = 1'b1;
                                end
                            end else begin
                                n_hout = HND_W'(SLOTS);
                            end
                        end
                        ACT_DELETE: begin
                            if (h_ok) begin
                                n_used[h_slot] = 1'b0;
                                n_free_count   = r_free_count + 1'b1;
                                n_status       = 1'b0;
                                if (!have_free) begin
                                    n_first_free = FF_W'(h_slot);
                                end
                            end
                        end
                        ACT_EXIST: begin
                            n_status = !h_ok;
                        end
                        ACT_SET: begin
                            n_status = !h_ok;
                        end
                        ACT_GET: begin
                            n_status = !h_ok;
                            n_get_ok = h_ok;
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{M_PAD_W{1'b0}}, rd_words, r_hout, r_status};
                    n_state   = r_scan_pend ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_rsp.done) begin
                    // With a consistent free count the search always hits;
                    // a miss keeps the remembered slot.
                    if (scan_rsp.found) begin
                        n_first_free = FF_W'(scan_rsp.slot);
                    end
                    n_scan_pend = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_used       <= '0;
            r_first_free <= '0;
            r_free_count <= FF_W'(SLOTS);
            r_scan_pend  <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_first_free <= n_first_free;
            r_free_count <= n_free_count;
            r_scan_pend  <= n_scan_pend;
            r_m_valid    <= n_m_valid;
        end
        r_status    <= n_status;
        r_hout      <= n_hout;
        r_get_ok    <= n_get_ok;
        r_scan_from <= n_scan_from;
        r_m_data    <= n_m_data;
    end

    hsa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_words (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    hsa_free_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scan_req),
        .i_used  (r_used),
        .o_rsp   (scan_rsp)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// ----- rtl/hsa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read; read data is registered and holds.
// ----------------------------------------------------------------------------
module hsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/hsa_free_scan.sv -----
// ----------------------------------------------------------------------------
// Free slot scan unit
// Two-stage circular search for the first free slot at or after a start slot.
// ----------------------------------------------------------------------------
module hsa_free_scan
    import hsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_req        i_req,
    input  logic [SLOTS-1:0] i_used,
    output t_scan_rsp        o_rsp
);

    logic               r_s1_valid;
    logic [NGRP_W-1:0]  r_sel_grp;
    logic               r_use_mask;
    logic [GROUP_W-1:0] r_off;
    logic               r_any;
    logic               r_done;
    logic               r_found;
    logic [SLOT_W-1:0]  r_slot;

    logic [NGRP_W-1:0]  start_grp;
    logic [GROUP_W-1:0] start_off;
    logic [GROUP-1:0]   start_bits;
    logic [NGROUPS-1:0] grp_free;
    logic [NGRP_W-1:0]  n_sel_grp;
    logic               grp_hit;
    logic [NGRP_W-1:0]  probe;

    logic [GROUP-1:0]   s2_bits;
    logic [GROUP_W-1:0] s2_idx;
    logic               s2_hit;

    assign start_grp = i_req.from[SLOT_W-1:GROUP_W];
    assign start_off = i_req.from[GROUP_W-1:0];

    // Stage one: try the tail of the start group, otherwise pick the next
    // group (circularly) that still holds a free slot.
    always_comb begin
        for (int i = 0; i < GROUP; i++) begin
            start_bits[i] = !i_used[{start_grp, GROUP_W'(i)}] && (GROUP_W'(i) >= start_off);
        end
        for (int g = 0; g < NGROUPS; g++) begin
            grp_free[g] = !(&i_used[g*GROUP +: GROUP]);
        end
        n_sel_grp = start_grp;
        grp_hit   = 1'b0;
        probe     = '0;
        for (int j = 0; j < NGROUPS; j++) begin
            probe = start_grp + NGRP_W'(j + 1);
            if (!grp_hit && grp_free[probe]) begin
                grp_hit   = 1'b1;
                n_sel_grp = probe;
            end
        end
    end

    // Stage two: lowest free slot in the chosen group, at or above the start
    // offset when the hit came from the start group's tail.
    always_comb begin
        for (int i = 0; i < GROUP; i++) begin
            s2_bits[i] = !i_used[{r_sel_grp, GROUP_W'(i)}] &&
                         (!r_use_mask || (GROUP_W'(i) >= r_off));
        end
        s2_idx = '0;
        s2_hit = 1'b0;
        for (int i = GROUP - 1; i >= 0; i--) begin
            if (s2_bits[i]) begin
                s2_hit = 1'b1;
                s2_idx = GROUP_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= i_req.start;
            r_done     <= r_s1_valid;
        end
        if (i_req.start) begin
            r_use_mask <= |start_bits;
            r_off      <= start_off;
            r_sel_grp  <= (|start_bits) ? start_grp : n_sel_grp;
            r_any      <= (|start_bits) || grp_hit;
        end
        if (r_s1_valid) begin
            r_found <= r_any && s2_hit;
            r_slot  <= {r_sel_grp, s2_idx};
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;
    assign o_rsp.slot  = r_slot;

endmodule

// ----- dv/hsa_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Handle slot allocator result checker
// Watches the request and result streams, keeps its own copy of the slot
// table, and compares every result beat field by field with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module hsa_result_checker
    import hsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [ACT_W-1:0]     i_s_tuser,   // action
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // handle_in, description_in,
                                              // param_a_in, param_b_in
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // status, handle_out,
                                              // description_out, param_a_out,
                                              // param_b_out, zero pad
    output int                   o_error_count,
    output int                   o_pending
);

    // Field order runs from the top bit down, so both structs line up with
    // the stream packing (first field in the lowest bits).
    typedef struct packed {
        logic [WORD_W-1:0] param_b;
        logic [WORD_W-1:0] param_a;
        logic [WORD_W-1:0] description;
        logic [HIN_W-1:0]  handle;
    } t_request;

    typedef struct packed {
        logic [WORD_W-1:0] param_b;
        logic [WORD_W-1:0] param_a;
        logic [WORD_W-1:0] description;
        logic [HND_W-1:0]  handle;
        logic              status;
    } t_slot_result;

    logic              slot_busy  [SLOTS];
    logic [WORD_W-1:0] slot_desc  [SLOTS];
    logic [WORD_W-1:0] slot_pa    [SLOTS];
    logic [WORD_W-1:0] slot_pb    [SLOTS];
    logic [HND_W-1:0]  first_free_slot;
    logic [HND_W-1:0]  free_slots;

    t_slot_result      expected_results [$];
    t_slot_result      want;
    t_slot_result      got;
    logic [M_PAD_W-1:0] pad;
    int                mismatches = 0;

    assign o_error_count = mismatches;

    // Applies one request to the table copy and returns the result it gives.
    function automatic t_slot_result serve_request(input logic [ACT_W-1:0] act,
                                                   input t_request req);
        t_slot_result      res;
        logic [HND_W-1:0]  idx;
        logic [SLOT_W-1:0] hs;
        logic              live;
        int                e;
        int                k;
        bit                found;
        res        = '0;
        res.status = 1'b1;
        hs         = req.handle[SLOT_W-1:0];
        live       = (req.handle < SLOTS) && slot_busy[hs];
        case (act)
            ACT_CREATE: begin
                if (first_free_slot < SLOTS) begin
                    idx        = first_free_slot;
                    free_slots = free_slots - 1'b1;
                    if (free_slots != 0) begin
                        // Circular search from the slot after the one handed out.
                        // If nothing turns up, the remembered slot is kept.
                        e     = (idx + 1) % SLOTS;
                        found = 1'b0;
                        for (k = 0; k < SLOTS && !found; k++) begin
                            if (!slot_busy[e]) begin
                                first_free_slot = HND_W'(e);
                                found           = 1'b1;
                            end else begin
                                e = (e + 1) % SLOTS;
                            end
                        end
                    end else begin
                        first_free_slot = HND_W'(SLOTS);
                    end
                    slot_desc[idx[SLOT_W-1:0]] = '0;
                    slot_pa[idx[SLOT_W-1:0]]   = '0;
                    slot_pb[idx[SLOT_W-1:0]]   = '0;
                    slot_busy[idx[SLOT_W-1:0]] = 1'b1;
                    res.status     = 1'b0;
                    res.handle     = idx;
                end else begin
                    res.handle = HND_W'(SLOTS);
                end
            end
            ACT_DELETE: begin
                if (live) begin
                    slot_desc[hs] = '0;
                    slot_pa[hs]   = '0;
                    slot_pb[hs]   = '0;
                    slot_busy[hs] = 1'b0;
                    free_slots    = free_slots + 1'b1;
                    if (first_free_slot >= SLOTS)
                        first_free_slot = HND_W'(hs);
                    res.status = 1'b0;
                end
            end
            ACT_EXIST: begin
                if (live)
                    res.status = 1'b0;
            end
            ACT_SET: begin
                if (live) begin
                    slot_desc[hs] = req.description;
                    slot_pa[hs]   = req.param_a;
                    slot_pb[hs]   = req.param_b;
                    res.status    = 1'b0;
                end
            end
            ACT_GET: begin
                if (live) begin
                    res.description = slot_desc[hs];
                    res.param_a     = slot_pa[hs];
                    res.param_b     = slot_pb[hs];
                    res.status      = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_busy[s] = 1'b0;
                slot_desc[s] = '0;
                slot_pa[s]   = '0;
                slot_pb[s]   = '0;
            end
            first_free_slot = '0;
            free_slots      = HND_W'(SLOTS);
            expected_results.delete();
        end else begin
            // Results first, so a beat that shows up with nothing pending is
            // never matched against a request taken on the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got = t_slot_result'(i_m_tdata[M_FIELD_W-1:0]);
                pad = i_m_tdata[M_TDATA_W-1:M_FIELD_W];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with no request pending: status=%0d "
                                 , $time, got.status,
                                 "handle=%0d desc=%h a=%h b=%h", got.handle,
                                 got.description, got.param_a, got.param_b);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.handle !== want.handle ||
                        got.description !== want.description ||
                        got.param_a !== want.param_a || got.param_b !== want.param_b ||
                        pad !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch: expected status=%0d ", $time,
                                     want.status,
                                     "handle=%0d desc=%h a=%h b=%h pad=0, got status=%0d ",
                                     want.handle, want.description, want.param_a,
                                     want.param_b, got.status,
                                     "handle=%0d desc=%h a=%h b=%h pad=%h",
                                     got.handle, got.description, got.param_a,
                                     got.param_b, pad);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(serve_request(i_s_tuser, t_request'(i_s_tdata)));
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- dv/tb_handle_slot_allocator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Handle slot allocator testbench
// Drives create, delete, exist, set and get requests with random gaps and
// result stalls, and leaves the checking to a checker that tracks the table.
// ----------------------------------------------------------------------------
module tb_handle_slot_allocator_top;
    import hsa_pkg::*;

    // The generous cycle limit covers roughly 1650 requests, each one paying
    // a full sender gap, a full receiver stall and a create's search, plus
    // the long hold-off, several times over.
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 16;

    // Request codes past the last defined one; the block must answer each with a failure.
    localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 3'd7;

    // Request mixes for the random phases.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND} t_mix;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [ACT_W-1:0]     s_tuser;    // action
    logic [S_TDATA_W-1:0] s_tdata;    // handle_in, description_in,
                                      // param_a_in, param_b_in
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // status, handle_out, description_out,
                                      // param_a_out, param_b_out, zero pad

    int error_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet_tail  = 1'b0;   // no gaps and no stalls near the end of the run
    bit hold_req    = 1'b0;   // asks the receiver for its one long hold-off
    bit hold_done   = 1'b0;

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    handle_slot_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    hsa_result_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tuser     (s_tuser),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_handle_slot_allocator_top: errors");
            $finish;
        end
    end

    // Offers one request beat and returns once it has been taken. Inputs
    // change only at the falling edge; tready is looked at on the rising
    // edge, where the beat is accepted. A beat that directly follows another
    // keeps tvalid high, so tvalid sees one assignment per time step.
    task automatic offer(input logic [ACT_W-1:0]  act,
                         input logic [HIN_W-1:0]  hnd,
                         input logic [WORD_W-1:0] desc,
                         input logic [WORD_W-1:0] pa,
                         input logic [WORD_W-1:0] pb);
        int gap;
        // About one beat in four is preceded by a burst of idle cycles, but
        // never while the receiver holds off, so the block really fills up.
        if (!quiet_tail && !(hold_req && !hold_done) && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {pb, pa, desc, hnd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // One random request. Most handles land inside the table, where they
    // have a fair chance of naming a used slot; the rest cover the whole
    // 16-bit field and its edges.
    task automatic offer_random(input t_mix mix);
        int               pick;
        int               hsel;
        logic [ACT_W-1:0] act;
        logic [ACT_W-1:0] rsvd;
        logic [HIN_W-1:0] hnd;
        pick = $urandom_range(0, 99);
        rsvd = ACT_W'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
        case (mix)
            MIX_FILL:
                act = pick < 80 ? ACT_CREATE : pick < 87 ? ACT_SET :
                      pick < 94 ? ACT_GET    : pick < 98 ? ACT_EXIST : ACT_DELETE;
            MIX_DRAIN:
                act = pick < 45 ? ACT_DELETE : pick < 60 ? ACT_GET :
                      pick < 75 ? ACT_SET    : pick < 85 ? ACT_EXIST :
                      pick < 92 ? ACT_CREATE : rsvd;
            default:
                act = pick < 25 ? ACT_CREATE : pick < 45 ? ACT_DELETE :
                      pick < 62 ? ACT_SET    : pick < 80 ? ACT_GET :
                      pick < 93 ? ACT_EXIST  : rsvd;
        endcase
        hsel = $urandom_range(0, 99);
        if (hsel < 88)
            hnd = HIN_W'($urandom_range(0, SLOTS - 1));
        else if (hsel < 95)
            hnd = HIN_W'($urandom_range(0, 16'hFFFF));
        else
            case ($urandom_range(0, 3))
                0:       hnd = '0;
                1:       hnd = HIN_W'(SLOTS - 1);
                2:       hnd = HIN_W'(SLOTS);
                default: hnd = '1;
            endcase
        offer(act, hnd, $urandom, $urandom, $urandom);
    endtask

    task automatic run_phase(input t_mix mix, input int count);
        repeat (count) offer_random(mix);
    endtask

    // Result side: random stall bursts, one long hold-off on request, and
    // a steady ready once the quiet tail begins.
    initial begin
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                // The block keeps its result in the output register, takes one more
                // request and then refuses new ones while the sender keeps offering.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                m_tready <= 1'b1;
                hold_done = 1'b1;
            end else if (quiet_tail || stall_left == 0) begin
                m_tready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 13);
            end else begin
                m_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Request side and verdict.
    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = ACT_CREATE;
        s_tdata  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Requests on slots nobody created must fail, as must
        // handles past the table and the all-ones handle.
        offer(ACT_EXIST,  16'd0,    '0, '0, '0);
        offer(ACT_GET,    16'hFFFF, '0, '0, '0);
        offer(ACT_DELETE, HIN_W'(SLOTS),     '0, '0, '0);
        offer(ACT_SET,    HIN_W'(SLOTS - 1), '1, '1, '1);
        // First creates hand out slots 0 and 1; data round trips with the
        // extreme words.
        offer(ACT_CREATE, 16'd0,    '1, '1, '1);
        offer(ACT_SET,    16'd0,    '1, '1, '1);
        offer(ACT_GET,    16'd0,    '0, '0, '0);
        offer(ACT_EXIST,  16'd0,    '0, '0, '0);
        offer(ACT_CREATE, 16'd0,    '0, '0, '0);
        offer(ACT_SET,    16'd1,    32'h8000_0001, 32'h0000_0000, 32'h7FFF_FFFE);
        offer(ACT_GET,    16'd1,    '0, '0, '0);
        // Deleting slot 0 while slot 2 is remembered as free leaves the
        // remembered slot alone, so the next create returns 2.
        offer(ACT_DELETE, 16'd0,    '0, '0, '0);
        offer(ACT_GET,    16'd0,    '0, '0, '0);
        offer(ACT_DELETE, 16'd0,    '0, '0, '0);
        offer(ACT_CREATE, 16'd0,    '0, '0, '0);
        offer(ACT_GET,    16'd2,    '0, '0, '0);
        // Unused request codes come back as failures with all other fields zero.
        offer(ACT_RSVD_FIRST,                16'd1, '1, '1, '1);
        offer(ACT_W'(ACT_RSVD_FIRST + 1'b1), 16'd2, '1, '1, '1);
        offer(ACT_RSVD_LAST,      16'hFFFF, '1, '1, '1);
        // Handles whose low byte names a live slot but whose upper bits are
        // set are still out of range.
        offer(ACT_EXIST,  16'h0101, '0, '0, '0);
        offer(ACT_SET,    16'hFF01, '1, '1, '1);
        offer(ACT_GET,    16'd1,    '0, '0, '0);
        offer(ACT_DELETE, 16'd1,    '0, '0, '0);
        offer(ACT_CREATE, 16'd0,    '0, '0, '0);

        // Random part. The first fill runs the table full, so creates start
        // failing and deletes then feed the empty first-free register. The
        // long hold-off lands while the table is full.
        run_phase(MIX_FILL, 330);
        hold_req = 1'b1;
        run_phase(MIX_DRAIN, 300);
        run_phase(MIX_BLEND, 200);
        run_phase(MIX_FILL, 250);
        run_phase(MIX_DRAIN, 250);
        quiet_tail = 1'b1;
        run_phase(MIX_BLEND, 300);
        @(negedge i_clk);
        s_tvalid <= 1'b0;

        // Let every predicted result arrive, then give the block a few more
        // cycles to show any stray beat.
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_handle_slot_allocator_top: clean");
        else
            $display("tb_handle_slot_allocator_top: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hsa_pkg.sv
rtl/hsa_ram.sv
rtl/hsa_free_scan.sv
rtl/handle_slot_allocator_top.sv
dv/hsa_result_checker.sv
dv/tb_handle_slot_allocator_top.sv
